// File: hdl/riff_wave_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// RIFF WAVE stream parser assertion macros
// Concurrent assertion wrappers on clk, one disabled by arst_n; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef RIFF_WAVE_STREAM_PARSER_ASSERT_SVH
`define RIFF_WAVE_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define RWSP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define RWSP_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define RWSP_ASSERT(label, prop)
`define RWSP_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: hdl/rwsp_pkg.sv
// ---------------------------------------------------------------------------
// RIFF WAVE stream parser package
// Item types, result codes and queue sizing shared by the parser files.
// ---------------------------------------------------------------------------
package rwsp_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NOT_RIFF  = 3'd1;
	localparam logic [2:0] STATUS_NOT_WAVE  = 3'd2;
	localparam logic [2:0] STATUS_FMT_EXT   = 3'd3;
	localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  sample_byte;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		logic [31:0] data_length;
		logic [2:0]  status;
		logic        last_of_item;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

// File: hdl/rwsp_parser_core.sv
// ---------------------------------------------------------------------------
// RIFF WAVE parser core
// Holds the parse state and turns one accepted byte into up to two results.
// ---------------------------------------------------------------------------
`include "riff_wave_stream_parser_assert.svh"

module rwsp_parser_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  rwsp_pkg::in_item_t item,
	output rwsp_pkg::push_t   push
);
	import rwsp_pkg::*;

	typedef enum logic [3:0] {
		PH_RIFF_TAG,
		PH_RIFF_SIZE,
		PH_WAVE_TAG,
		PH_CHUNK_ID,
		PH_CHUNK_SIZE,
		PH_FMT_BODY,
		PH_AFTER_FMT,
		PH_CBSIZE_HI,
		PH_DATA_BODY,
		PH_SKIP_BODY,
		PH_DONE
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	phase_t      phase_q, ph;
	logic [4:0]  pos_q, pos;
	logic [31:0] rem_q, rem;
	logic [31:0] tag_q, tag;
	logic [31:0] fld_q, fld;
	logic [15:0] chan_q, chan;
	logic [31:0] rate_q, rate;
	logic [15:0] depth_q, depth;
	logic [31:0] dlen_q, dlen;
	logic        e0_v, e1_v;
	logic [1:0]  e0_kind, e1_kind;
	logic [7:0]  e0_sample;
	logic [2:0]  e0_status, e1_status;
	out_item_t   r0, r1;
	logic [7:0]  b;

	function automatic logic is_letter(input logic [7:0] v);
		return ((v >= 8'h41) && (v <= 8'h5A)) || ((v >= 8'h61) && (v <= 8'h7A));
	endfunction

	assign b = item.data_byte;

	always_comb begin
		ph = phase_q;
		pos = pos_q;
		rem = rem_q;
		tag = tag_q;
		fld = fld_q;
		chan = chan_q;
		rate = rate_q;
		depth = depth_q;
		dlen = dlen_q;
		e0_v = 1'b0;
		e0_kind = KIND_SAMPLE;
		e0_sample = 8'd0;
		e0_status = STATUS_OK;
		e1_v = 1'b0;
		e1_kind = KIND_FINISH;
		e1_status = STATUS_OK;

		if (ph == PH_AFTER_FMT && is_letter(b)) begin
			ph = PH_CHUNK_ID;
			pos = 5'd0;
		end

		case (ph)
			PH_RIFF_TAG, PH_WAVE_TAG: begin
				tag = {b, tag[31:8]};
				pos = pos + 5'd1;
				if (pos >= 5'd4) begin
					pos = 5'd0;
					if (ph == PH_RIFF_TAG) begin
						if (tag == TAG_RIFF) begin
							ph = PH_RIFF_SIZE;
						end else begin
							e0_v = 1'b1;
							e0_kind = KIND_ERROR;
							e0_status = STATUS_NOT_RIFF;
							ph = PH_DONE;
						end
					end else begin
						if (tag == TAG_WAVE) begin
							ph = PH_CHUNK_ID;
						end else begin
							e0_v = 1'b1;
							e0_kind = KIND_ERROR;
							e0_status = STATUS_NOT_WAVE;
							ph = PH_DONE;
						end
					end
				end
			end
			PH_RIFF_SIZE: begin
				pos = pos + 5'd1;
				if (pos >= 5'd4) begin
					pos = 5'd0;
					ph = PH_WAVE_TAG;
				end
			end
			PH_CHUNK_ID: begin
				if (pos == 5'd0 && !is_letter(b)) begin
					e0_v = 1'b1;
					e0_kind = KIND_FINISH;
					ph = PH_DONE;
				end else begin
					tag = {b, tag[31:8]};
					pos = pos + 5'd1;
					if (pos >= 5'd4) begin
						pos = 5'd0;
						ph = PH_CHUNK_SIZE;
					end
				end
			end
			PH_CHUNK_SIZE: begin
				fld = {b, fld[31:8]};
				pos = pos + 5'd1;
				if (pos >= 5'd4) begin
					pos = 5'd0;
					rem = fld;
					if (tag == TAG_FMT) begin
						ph = PH_FMT_BODY;
					end else if (tag == TAG_DATA) begin
						dlen = fld;
						ph = (fld != 32'd0) ? PH_DATA_BODY : PH_CHUNK_ID;
					end else begin
						ph = (fld != 32'd0) ? PH_SKIP_BODY : PH_CHUNK_ID;
					end
				end
			end
			PH_FMT_BODY: begin
				case (pos)
					5'd2:  chan = {8'd0, b};
					5'd3:  chan[15:8] = b;
					5'd4:  rate = {24'd0, b};
					5'd5:  rate[15:8] = b;
					5'd6:  rate[23:16] = b;
					5'd7:  rate[31:24] = b;
					5'd14: depth = {8'd0, b};
					5'd15: depth[15:8] = b;
					default: ;
				endcase
				pos = pos + 5'd1;
				if (pos >= 5'd16) begin
					pos = 5'd0;
					e0_v = 1'b1;
					e0_kind = KIND_FORMAT;
					ph = PH_AFTER_FMT;
				end
			end
			PH_AFTER_FMT: begin
				fld = {24'd0, b};
				ph = PH_CBSIZE_HI;
			end
			PH_CBSIZE_HI: begin
				fld = {16'd0, b, fld[7:0]};
				if (fld == 32'd0) begin
					ph = PH_CHUNK_ID;
					pos = 5'd0;
				end else begin
					e0_v = 1'b1;
					e0_kind = KIND_ERROR;
					e0_status = STATUS_FMT_EXT;
					ph = PH_DONE;
				end
			end
			PH_DATA_BODY: begin
				e0_v = 1'b1;
				e0_kind = KIND_SAMPLE;
				e0_sample = b;
				rem = rem - 32'd1;
				if (rem == 32'd0) begin
					ph = PH_CHUNK_ID;
				end
			end
			PH_SKIP_BODY: begin
				rem = rem - 32'd1;
				if (rem == 32'd0) begin
					ph = PH_CHUNK_ID;
				end
			end
			default: begin
				ph = PH_DONE;
			end
		endcase

		if (item.last_byte) begin
			if ((ph == PH_CHUNK_ID && pos == 5'd0) || ph == PH_AFTER_FMT) begin
				e1_v = 1'b1;
				e1_kind = KIND_FINISH;
			end else if (ph != PH_DONE) begin
				e1_v = 1'b1;
				e1_kind = KIND_ERROR;
				e1_status = STATUS_TRUNCATED;
			end
		end

		r0.result_kind = e0_kind;
		r0.sample_byte = e0_sample;
		r0.channel_count = chan;
		r0.sample_rate = rate;
		r0.bits_per_sample = depth;
		r0.data_length = dlen;
		r0.status = e0_status;
		r0.last_of_item = !e1_v;

		r1 = r0;
		r1.result_kind = e1_kind;
		r1.sample_byte = 8'd0;
		r1.status = e1_status;
		r1.last_of_item = 1'b1;

		push.first = e0_v ? r0 : r1;
		push.second = r1;
		push.count = accept ? (2'({1'b0, e0_v}) + 2'({1'b0, e1_v})) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF_TAG;
			pos_q <= 5'd0;
			rem_q <= 32'd0;
			tag_q <= 32'd0;
			fld_q <= 32'd0;
			chan_q <= 16'd0;
			rate_q <= 32'd0;
			depth_q <= 16'd0;
			dlen_q <= 32'd0;
		end else if (accept) begin
			if (item.last_byte) begin
				phase_q <= PH_RIFF_TAG;
				pos_q <= 5'd0;
				rem_q <= 32'd0;
				tag_q <= 32'd0;
				fld_q <= 32'd0;
				chan_q <= 16'd0;
				rate_q <= 32'd0;
				depth_q <= 16'd0;
				dlen_q <= 32'd0;
			end else begin
				phase_q <= ph;
				pos_q <= pos;
				rem_q <= rem;
				tag_q <= tag;
				fld_q <= fld;
				chan_q <= chan;
				rate_q <= rate;
				depth_q <= depth;
				dlen_q <= dlen;
			end
		end
	end

	`RWSP_ASSERT(a_two_results_only_on_last, (push.count == 2'd2) |-> item.last_byte)
	`RWSP_ASSERT(a_pos_in_range, pos_q < 5'd16)
	`RWSP_ASSERT(a_last_returns_to_start,
		(accept && item.last_byte) |=> (phase_q == PH_RIFF_TAG && pos_q == 5'd0))
	`RWSP_ASSERT(a_data_body_nonzero, (phase_q == PH_DATA_BODY) |-> (rem_q != 32'd0))

endmodule

// File: hdl/rwsp_result_fifo.sv
// ---------------------------------------------------------------------------
// RIFF WAVE result queue
// Small register queue: takes up to two results per cycle, sends one if ready.
// ---------------------------------------------------------------------------
`include "riff_wave_stream_parser_assert.svh"

module rwsp_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  rwsp_pkg::push_t    push,
	output logic               room,
	output logic               result_valid,
	input  logic               result_ready,
	output rwsp_pkg::out_item_t result_item
);
	import rwsp_pkg::*;

	out_item_t        entries [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_next;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign wr_next = wr_q + PTR_W'(1);
	assign pop = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result_item = entries[rd_q];
	assign room = (count_q <= CNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entries[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(push.count);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`RWSP_ASSERT(a_count_bounded, count_q <= CNT_W'(QUEUE_DEPTH))
	`RWSP_ASSERT(a_ptrs_match_count, PTR_W'(wr_q - rd_q) == PTR_W'(count_q))
	`RWSP_ASSERT(a_push_two_grows,
		(push.count == 2'd2 && !pop) |=> (count_q == CNT_W'($past(count_q) + CNT_W'(2))))
	`RWSP_ASSERT(a_pop_only_shrinks,
		(push.count == 2'd0 && pop) |=> (count_q == CNT_W'($past(count_q) - CNT_W'(1))))

endmodule

// File: hdl/riff_wave_stream_parser.sv
// ---------------------------------------------------------------------------
// RIFF WAVE stream parser
// Parses a RIFF WAVE byte stream into sample, format, finish and error results.
// ---------------------------------------------------------------------------
// Bytes of the file arrive on the byte channel, one item per byte, with
// last_byte set on the final byte. Results leave on the result channel:
// sample bytes of the data chunk, a format report after the fmt body,
// a finish item, or an error item with its status code.
// One byte is taken every cycle while the queue has room; the parse state is
// updated in the same cycle, so there is no dependency stall between bytes.
// Each result is written into the queue when its byte is taken. The final
// byte of a file may cause two results; both are queued and leave in order.
// Results wait in a four-entry queue; the byte channel stays ready while the
// queue has room for two results, so a stalled receiver blocks input once the
// queue holds more than two results.
// Reset clears the parse state to expect a RIFF tag and empties the queue.
// ---------------------------------------------------------------------------
module riff_wave_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  rwsp_pkg::in_item_t  byte_item,
	output logic                result_valid,
	input  logic                result_ready,
	output rwsp_pkg::out_item_t result_item
);
	import rwsp_pkg::*;

	push_t push;
	logic  accept;

	assign accept = byte_valid && byte_ready;

	rwsp_parser_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push)
	);

	rwsp_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (byte_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule
